FILE: hw/rtl/bffs_pkg.sv
// Shared types and constants for the seeded FNV-1a Bloom filter.
// No dependencies.
package bffs_pkg;
  localparam int MaxBits = 32768;
  localparam int MaxSeeds = 8;
  localparam int StoreWords = (MaxBits + 63) / 64;
  localparam int WordAw = $clog2(StoreWords);
  localparam int SeedAw = $clog2(MaxSeeds);
  localparam int BitAw = $clog2(MaxBits);
  localparam logic [63:0] FnvPrime = 64'd1099511628211;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_SEED   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  localparam logic CFG_BIT_COUNT = 1'b0;
  localparam logic CFG_HASH_COUNT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_MUL, ST_NEXT, ST_MOD, ST_RD, ST_WAIT, ST_UPD, ST_DONE, ST_CLR
  } state_t;
endpackage

FILE: hw/rtl/bffs_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module bffs_ram #(
  parameter int Width = 64,
  parameter int Depth = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: hw/rtl/bffs_serial_mul.sv
// Bit-serial 64-bit multiplier by the FNV prime, modulo 2^64.
// Depends on bffs_pkg.
module bffs_serial_mul import bffs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] operand,
  output logic        done,
  output logic [63:0] product
);
  logic [63:0] acc_r, acc_nxt, mc_r, mc_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;

  // Shift-add over the prime's bits, one bit per cycle.
  always_comb begin
    acc_nxt = acc_r;
    mc_nxt = mc_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    if (start) begin
      acc_nxt = '0;
      mc_nxt = operand;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (FnvPrime[cnt_r[5:0]]) acc_nxt = acc_r + mc_r;
      mc_nxt = {mc_r[62:0], 1'b0};
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) run_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    mc_r <= mc_nxt;
  end

  assign done = run_r && (cnt_r == 7'd63);
  assign product = acc_nxt;
endmodule

FILE: hw/rtl/bffs_serial_mod.sv
// Restoring bit-serial remainder of a 64-bit value by a 16-bit divisor.
// Depends on bffs_pkg.
module bffs_serial_mod import bffs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] remainder
);
  logic [63:0] sh_r, sh_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [16:0] trial;
  logic [15:0] dv_r, dv_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;

  always_comb begin
    sh_nxt = sh_r;
    rem_nxt = rem_r;
    dv_nxt = dv_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    trial = {rem_r, sh_r[63]};
    if (start) begin
      sh_nxt = dividend;
      rem_nxt = '0;
      dv_nxt = divisor;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      sh_nxt = {sh_r[62:0], 1'b0};
      rem_nxt = (trial >= {1'b0, dv_r}) ? 16'(trial - {1'b0, dv_r}) : trial[15:0];
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) run_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
    sh_r <= sh_nxt;
    rem_r <= rem_nxt;
    dv_r <= dv_nxt;
  end

  assign done = run_r && (cnt_r == 7'd63);
  assign remainder = rem_nxt;
endmodule

FILE: hw/rtl/bloom_filter_fnv_seeded_top.sv
// Top level of the seeded FNV-1a Bloom filter: control sequencer and storage.
// Depends on bffs_pkg, bffs_ram, bffs_serial_mul and bffs_serial_mod.
//
// Usage: pulse start with a command while busy is low. Insert and query
// commands carry one key byte each, last_byte marks the key end. Load seed
// writes one seed slot and leaves busy low. Clear sweeps the 512-word bit
// store, one word per cycle, and the same sweep runs after reset,
// during which busy is high; cfg writes are taken at any time.
// Each key byte runs every seed slot through a bit-serial multiplier by the
// FNV prime: per slot, a start and then one shift-add step per prime bit.
// At the last byte each active hash is reduced by a bit-serial remainder
// unit, and then the bit store word is read, set for an insert or tested
// for a query (states RD, WAIT, UPD); a final DONE state ends the key. A
// query result appears on out_valid with out_hit for exactly one cycle
// when the sequence ends; the receiver cannot stall it.
module bloom_filter_fnv_seeded_top import bffs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_key_byte,
  input  logic        in_last_byte,
  input  logic [2:0]  in_seed_index,
  input  logic [63:0] in_seed_value,
  output logic        out_valid,
  output logic        out_hit,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  state_t state_r, state_nxt;
  logic [15:0] bit_count_r;
  logic [3:0]  hash_count_r;
  logic [63:0] seed_r [MaxSeeds];
  logic [63:0] run_r [MaxSeeds];
  logic        in_key_r;
  logic [SeedAw:0] slot_r, slot_nxt;
  logic [1:0]  cmd_r;
  logic [7:0]  byte_r;
  logic        last_r;
  logic        hit_r, hit_nxt;
  logic [WordAw-1:0] clr_r, clr_nxt;
  logic [15:0] bit_r;
  logic        acc;
  logic        mul_start, mul_done, mod_start, mod_done;
  logic [63:0] mul_prod;
  logic [15:0] mod_rem, nbits;
  logic [3:0]  nh;
  logic        ram_we;
  logic [WordAw-1:0] ram_addr;
  logic [63:0] ram_wdata, ram_rdata, mask;

  assign acc = start && !busy;
  assign nbits = (bit_count_r == 16'd0) ? 16'd1 :
                 (bit_count_r > 16'(MaxBits)) ? 16'(MaxBits) : bit_count_r;
  assign nh = (hash_count_r > 4'(MaxSeeds)) ? 4'(MaxSeeds) : hash_count_r;
  assign mask = 64'd1 << bit_r[5:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          unique case (cmd_t'(in_command))
            CMD_SEED: state_nxt = ST_IDLE;
            CMD_CLEAR: state_nxt = ST_CLR;
            default: state_nxt = ST_LOAD;
          endcase
        end
      end
      ST_LOAD: state_nxt = ST_MUL;
      ST_MUL: if (mul_done) state_nxt = ST_NEXT;
      ST_NEXT: begin
        if (slot_r != (SeedAw + 1)'(MaxSeeds - 1)) state_nxt = ST_MUL;
        else if (!last_r) state_nxt = ST_IDLE;
        else if (nh == 4'd0) state_nxt = ST_DONE;
        else state_nxt = ST_MOD;
      end
      ST_MOD: if (mod_done) state_nxt = ST_RD;
      ST_RD: state_nxt = ST_WAIT;
      ST_WAIT: state_nxt = ST_UPD;
      ST_UPD: state_nxt = ((slot_r + 1'b1) == (SeedAw + 1)'(nh)) ? ST_DONE : ST_MOD;
      ST_DONE: state_nxt = ST_IDLE;
      ST_CLR: if (clr_r == WordAw'(StoreWords - 1)) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = (state_r != ST_IDLE);
    mul_start = (state_r == ST_LOAD) ||
                (state_r == ST_NEXT && slot_r != (SeedAw + 1)'(MaxSeeds - 1));
    mod_start = (state_r == ST_NEXT && slot_r == (SeedAw + 1)'(MaxSeeds - 1)
                 && last_r && nh != 4'd0) ||
                (state_r == ST_UPD && state_nxt == ST_MOD);
    out_valid = (state_r == ST_DONE) && (cmd_r == CMD_QUERY);
    out_hit = hit_r;
    ram_we = 1'b0;
    ram_addr = bit_r[BitAw-1:6];
    ram_wdata = ram_rdata | mask;
    if (state_r == ST_CLR) begin
      ram_we = 1'b1;
      ram_addr = clr_r;
      ram_wdata = '0;
    end else if (state_r == ST_UPD && cmd_r == CMD_INSERT) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    slot_nxt = slot_r;
    hit_nxt = hit_r;
    clr_nxt = clr_r;
    if (state_r == ST_IDLE && acc) begin
      slot_nxt = '0;
      hit_nxt = 1'b1;
      clr_nxt = '0;
    end
    if (state_r == ST_NEXT) begin
      slot_nxt = (slot_r == (SeedAw + 1)'(MaxSeeds - 1)) ? '0 : slot_r + 1'b1;
    end
    if (state_r == ST_UPD) begin
      slot_nxt = slot_r + 1'b1;
      if (cmd_r == CMD_QUERY && (ram_rdata & mask) == 64'd0) hit_nxt = 1'b0;
    end
    if (state_r == ST_CLR) clr_nxt = clr_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      slot_r <= '0;
      hit_r <= 1'b1;
      clr_r <= '0;
      in_key_r <= 1'b0;
      bit_count_r <= 16'd32768;
      hash_count_r <= 4'd1;
      for (int i = 0; i < MaxSeeds; i++) seed_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      slot_r <= slot_nxt;
      hit_r <= hit_nxt;
      clr_r <= clr_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_BIT_COUNT) bit_count_r <= cfg_data;
        else if (cfg_index == CFG_HASH_COUNT) hash_count_r <= cfg_data[3:0];
      end
      if (acc && in_command == CMD_SEED) seed_r[in_seed_index] <= in_seed_value;
      if (acc && (in_command == CMD_INSERT || in_command == CMD_QUERY)) begin
        in_key_r <= !in_last_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      cmd_r <= in_command;
      byte_r <= in_key_byte;
      last_r <= in_last_byte;
    end
    if (acc && !in_key_r && (in_command == CMD_INSERT || in_command == CMD_QUERY)) begin
      for (int i = 0; i < MaxSeeds; i++) run_r[i] <= seed_r[i];
    end
    if (mul_done) run_r[slot_r[SeedAw-1:0]] <= mul_prod;
    if (mod_done) bit_r <= mod_rem;
  end

  bffs_serial_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start),
    .operand(run_r[slot_nxt[SeedAw-1:0]] ^ {56'd0, byte_r}),
    .done(mul_done), .product(mul_prod)
  );

  bffs_serial_mod u_mod (
    .clk(clk), .rst_n(rst_n), .start(mod_start),
    .dividend(run_r[slot_nxt[SeedAw-1:0]]), .divisor(nbits),
    .done(mod_done), .remainder(mod_rem)
  );

  bffs_ram #(.Width(64), .Depth(StoreWords)) u_store (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !acc) else $error("transaction accepted while busy");
  a_out_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cmd_r == CMD_QUERY) else $error("result for non-query");
  a_units_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_start && mod_start)) else $error("both units started");
  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_RD) |-> bit_r < nbits) else $error("bit index out of range");
`endif
endmodule
